/* src/brn_pkg.sv */
// Shared constants, types and codes of the bilinear resize and normalize block.
package brn_pkg;

  localparam int MAX_SRC_DIM = 512;
  localparam int MAX_DST_DIM = 4096;
  localparam int WEIGHT_BITS = 16;

  localparam int SIDX_W  = $clog2(MAX_SRC_DIM);
  localparam int SDIM_W  = 10;
  localparam int DDIM_W  = 13;
  localparam int COORD_W = 12;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int ADDR_W  = 2 * SIDX_W;
  localparam int DEPTH   = MAX_SRC_DIM * MAX_SRC_DIM;

  // Axis division: Q = floor(num * 2^WEIGHT_BITS / (2 * dst_size)).
  localparam int DEN_W = DDIM_W + 1;
  localparam int NUM_W = DEN_W + SIDX_W;
  localparam int QUO_W = SIDX_W + WEIGHT_BITS;

  // Blend and normalization widths.
  localparam int WT1_W    = WEIGHT_BITS + 1;
  localparam int TOP_W    = CH_W + WEIGHT_BITS;
  localparam int V_W      = TOP_W + WEIGHT_BITS;
  localparam int OUT_W    = 16;
  localparam int OUT_FRAC = 14;
  localparam int NSH      = 2 * WEIGHT_BITS - OUT_FRAC + 1;
  localparam int Y_W      = V_W + 2 - NSH;
  localparam int RECIP_W  = Y_W - 7;
  localparam int RECIP    = ((2 ** Y_W) + 254) / 255;

  localparam logic [WT1_W-1:0] W_ONE  = WT1_W'(1) << WEIGHT_BITS;
  localparam logic [V_W:0]     FULL_V = (V_W + 1)'(255) << (2 * WEIGHT_BITS);
  localparam logic [V_W+1:0]   HALF_Q = (V_W + 2)'(255) << (2 * WEIGHT_BITS - OUT_FRAC);
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd2;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd3;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_WRITE,
    KIND_READ,
    KIND_ERROR
  } kind_t;

  // One request as it moves through the divider pipeline.
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  waddr;
    logic [PIX_W-1:0]   pix;
    logic [SIDX_W-1:0]  ylast;
    logic [SIDX_W-1:0]  xlast;
    logic [DEN_W-1:0]   den_y;
    logic [DEN_W-1:0]   den_x;
    logic [DEN_W-1:0]   rem_y;
    logic [DEN_W-1:0]   rem_x;
    logic [QUO_W-1:0]   quo_y;
    logic [QUO_W-1:0]   quo_x;
  } item_t;

  // Four fetched neighbors with their weights.
  typedef struct packed {
    logic                   err;
    logic [WEIGHT_BITS-1:0] wx;
    logic [WEIGHT_BITS-1:0] wy;
    logic [PIX_W-1:0]       p00;
    logic [PIX_W-1:0]       p01;
    logic [PIX_W-1:0]       p10;
    logic [PIX_W-1:0]       p11;
  } bundle_t;

endpackage

/* src/brn_if.sv */
// Request and result channel interfaces of the resize block.
interface brn_req_if;
  import brn_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [CH_W-1:0]    red_in;
  logic [CH_W-1:0]    green_in;
  logic [CH_W-1:0]    blue_in;
  modport source(output valid, operation, row, col, red_in, green_in, blue_in,
                 input ready);
  modport sink(input valid, operation, row, col, red_in, green_in, blue_in,
               output ready);
endinterface

interface brn_rsp_if;
  import brn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] red_out;
  logic signed [OUT_W-1:0] green_out;
  logic signed [OUT_W-1:0] blue_out;
  logic                    range_error;
  modport source(output valid, red_out, green_out, blue_out, range_error, input ready);
  modport sink(input valid, red_out, green_out, blue_out, range_error, output ready);
endinterface

/* src/brn_divpipe.sv */
// Pipelined restoring divider that maps both axes to source index and weight.
module brn_divpipe (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  brn_pkg::item_t in_item,
  output logic          tail_valid,
  output brn_pkg::item_t tail,
  input  logic          pop
);
  import brn_pkg::*;

  localparam int STEPS = QUO_W;

  item_t            st [STEPS];
  logic [STEPS-1:0] vld;
  logic             adv;

  // One quotient bit per axis.
  function automatic item_t div_step(item_t it);
    item_t        o;
    logic [DEN_W:0] ry;
    logic [DEN_W:0] rx;
    logic         qy;
    logic         qx;
    o  = it;
    ry = {it.rem_y, it.quo_y[QUO_W-1]};
    rx = {it.rem_x, it.quo_x[QUO_W-1]};
    qy = (ry >= {1'b0, it.den_y});
    qx = (rx >= {1'b0, it.den_x});
    o.rem_y = qy ? DEN_W'(ry - {1'b0, it.den_y}) : ry[DEN_W-1:0];
    o.rem_x = qx ? DEN_W'(rx - {1'b0, it.den_x}) : rx[DEN_W-1:0];
    o.quo_y = {it.quo_y[QUO_W-2:0], qy};
    o.quo_x = {it.quo_x[QUO_W-2:0], qx};
    return o;
  endfunction

  assign adv        = !vld[STEPS-1] || pop;
  assign in_ready   = adv;
  assign tail_valid = vld[STEPS-1];
  assign tail       = st[STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= div_step(in_item);
      for (int k = 1; k < STEPS; k++) begin
        st[k] <= div_step(st[k-1]);
      end
    end
  end

endmodule

/* src/brn_fetch.sv */
// Source pixel memory with the write and four-neighbor read sequencer.
module brn_fetch (
  input  logic             clk,
  input  logic             rst,
  input  logic             tail_valid,
  input  brn_pkg::item_t   tail,
  output logic             pop,
  output logic             fb_valid,
  output brn_pkg::bundle_t fb,
  input  logic             fb_take
);
  import brn_pkg::*;

  localparam logic [1:0] NB_00 = 2'd0;
  localparam logic [1:0] NB_01 = 2'd1;
  localparam logic [1:0] NB_10 = 2'd2;
  localparam logic [1:0] NB_11 = 2'd3;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;

  logic [1:0]  ph;
  logic        ret_valid;
  logic [1:0]  ret_tag;
  logic        ret_err;
  logic [WEIGHT_BITS-1:0] ret_wx;
  logic [WEIGHT_BITS-1:0] ret_wy;
  logic [PIX_W-1:0] b0, b1, b2;

  logic [SIDX_W-1:0] y0, y1, x0, x1;
  logic [SIDX_W-1:0] ry, rx;
  logic [ADDR_W-1:0] maddr;
  logic hold, step, mem_we, mem_re, err_step;

  always_comb begin
    y0 = tail.quo_y[QUO_W-1:WEIGHT_BITS];
    x0 = tail.quo_x[QUO_W-1:WEIGHT_BITS];
    y1 = (y0 < tail.ylast) ? SIDX_W'(y0 + 1'b1) : tail.ylast;
    x1 = (x0 < tail.xlast) ? SIDX_W'(x0 + 1'b1) : tail.xlast;
    case (ph)
      NB_00: begin ry = y0; rx = x0; end
      NB_01: begin ry = y0; rx = x1; end
      NB_10: begin ry = y1; rx = x0; end
      NB_11: begin ry = y1; rx = x1; end
      default: begin ry = y0; rx = x0; end
    endcase
  end

  // The last neighbor waits in the read register while the bundle slot is full.
  assign hold     = ret_valid && (ret_tag == NB_11) && fb_valid && !fb_take;
  assign step     = tail_valid && !hold;
  assign mem_we   = step && (tail.kind == KIND_WRITE);
  assign mem_re   = step && (tail.kind == KIND_READ);
  assign err_step = step && (tail.kind == KIND_ERROR);
  assign pop      = step && ((tail.kind != KIND_READ) || (ph == NB_11));
  assign maddr    = mem_we ? tail.waddr : {ry, rx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[maddr] <= tail.pix;
    end
    if (mem_re) begin
      rdata <= mem[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= NB_00;
      ret_valid <= 1'b0;
    end else begin
      if (mem_re) begin
        ph <= ph + 2'd1;
      end
      if (!hold) begin
        ret_valid <= mem_re || err_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      ret_tag <= err_step ? NB_11 : ph;
      ret_err <= err_step;
      ret_wx  <= tail.quo_x[WEIGHT_BITS-1:0];
      ret_wy  <= tail.quo_y[WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ret_valid && !hold) begin
      case (ret_tag)
        NB_00: b0 <= rdata;
        NB_01: b1 <= rdata;
        NB_10: b2 <= rdata;
        NB_11: begin
          fb.p00 <= b0;
          fb.p01 <= b1;
          fb.p10 <= b2;
          fb.p11 <= rdata;
          fb.wx  <= ret_wx;
          fb.wy  <= ret_wy;
          fb.err <= ret_err;
        end
        default: b0 <= rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
    end else if (ret_valid && !hold && (ret_tag == NB_11)) begin
      fb_valid <= 1'b1;
    end else if (fb_take) begin
      fb_valid <= 1'b0;
    end
  end

endmodule

/* src/brn_blend.sv */
// Bilinear blend, normalization to signed Q2.14 and the result register.
module brn_blend (
  input  logic             clk,
  input  logic             rst,
  input  logic             fb_valid,
  input  brn_pkg::bundle_t fb,
  output logic             fb_take,
  brn_rsp_if.source        result
);
  import brn_pkg::*;

  logic en;
  logic v1, v2, v3, o_valid;

  logic [TOP_W-1:0] top1 [3];
  logic [TOP_W-1:0] bot1 [3];
  logic [WEIGHT_BITS-1:0] wy1;
  logic err1, err2, err3;
  logic [V_W-1:0] val2 [3];
  logic [Y_W-1:0] y3 [3];
  logic [RECIP_W-1:0] q3 [3];
  logic neg3 [3];

  logic [TOP_W:0] t_top [3];
  logic [TOP_W:0] t_bot [3];
  logic [V_W:0]   t_v [3];
  logic [V_W:0]   t_two [3];
  logic [V_W:0]   t_mag [3];
  logic [V_W+1:0] t_x [3];
  logic [Y_W-1:0] t_y [3];
  logic [Y_W+RECIP_W-1:0] t_prod [3];
  logic t_neg [3];
  logic [Y_W:0] t_chk [3];
  logic [RECIP_W-1:0] t_q [3];
  logic [OUT_W-1:0] t_res [3];
  logic [WT1_W-1:0] swx, swy;

  assign en      = !o_valid || result.ready;
  assign fb_take = en;
  assign swx     = W_ONE - {1'b0, fb.wx};
  assign swy     = W_ONE - {1'b0, wy1};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t_top[c] = fb.p00[CH_W*c +: CH_W] * swx + fb.p01[CH_W*c +: CH_W] * {1'b0, fb.wx};
      t_bot[c] = fb.p10[CH_W*c +: CH_W] * swx + fb.p11[CH_W*c +: CH_W] * {1'b0, fb.wx};
      t_v[c]   = top1[c] * swy + bot1[c] * {1'b0, wy1};
      // Map 2*v/255 - 1 with rounding to nearest, ties away from zero.
      t_two[c] = {val2[c], 1'b0};
      t_neg[c] = (t_two[c] < FULL_V);
      t_mag[c] = t_neg[c] ? (FULL_V - t_two[c]) : (t_two[c] - FULL_V);
      t_x[c]   = {t_mag[c], 1'b0} + HALF_Q;
      t_y[c]   = t_x[c][V_W+1:NSH];
      t_prod[c] = t_y[c] * RECIP_K;
      // The reciprocal estimate is high by at most one.
      t_chk[c] = {q3[c], 8'b0} - (Y_W + 1)'(q3[c]);
      t_q[c]   = (t_chk[c] > {1'b0, y3[c]}) ? RECIP_W'(q3[c] - 1'b1) : q3[c];
      t_res[c] = neg3[c] ? OUT_W'(-t_q[c]) : OUT_W'(t_q[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      v1      <= fb_valid;
      v2      <= v1;
      v3      <= v2;
      o_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        top1[c] <= t_top[c][TOP_W-1:0];
        bot1[c] <= t_bot[c][TOP_W-1:0];
        val2[c] <= t_v[c][V_W-1:0];
        y3[c]   <= t_y[c];
        q3[c]   <= t_prod[c][Y_W+RECIP_W-1:Y_W];
        neg3[c] <= t_neg[c];
      end
      wy1  <= fb.wy;
      err1 <= fb.err;
      err2 <= err1;
      err3 <= err2;
      result.red_out     <= err3 ? '0 : t_res[0];
      result.green_out   <= err3 ? '0 : t_res[1];
      result.blue_out    <= err3 ? '0 : t_res[2];
      result.range_error <= err3;
    end
  end

  assign result.valid = o_valid;

endmodule

/* src/bilinear_image_resize_normalize.sv */
// Top level: configuration registers, request decode and the processing chain.
//
// Requests arrive on the request channel. A write request (operation 0) stores
// one RGB pixel at (row, col) of the source image; writes outside the source
// size are dropped, and no write gives a result. A read request (operation 1)
// names a destination pixel and gives one result: the bilinear blend of four
// source neighbors, mapped to 2*v/255-1 in signed Q2.14 per channel, or zeros
// with range_error set when row or col lies outside the destination size.
// Requests are handled strictly in order, so a read sees every earlier write.
// A read passes through 25 divider stages, four memory reads, three blend
// stages and the result register. Reads are limited by the single port of
// the source memory, which takes one neighbor per cycle; the last neighbor
// waits while the bundle slot is full. Reset sets all four size registers
// to 1; the source memory is not cleared and must be written before it is
// read. When the receiver stalls, results wait in the result register and
// the pipeline stops behind it, then the request channel drops ready. The
// user must write the registers over the APB port only while no request is
// in flight; the block itself does not enforce this.
module bilinear_image_resize_normalize (
  input  logic                        clk,
  input  logic                        rst,
  brn_req_if.sink                     request,
  brn_rsp_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [brn_pkg::PADDR_W-1:0] paddr,
  input  logic [brn_pkg::PDATA_W-1:0] pwdata,
  output logic [brn_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import brn_pkg::*;

  logic [SDIM_W-1:0] src_height, src_width;
  logic [DDIM_W-1:0] dst_height, dst_width;
  logic [SDIM_W-1:0] sh, sw;
  logic [DDIM_W-1:0] dh, dw;
  logic [1:0]        reg_idx;

  logic [NUM_W:0] py, px, ny, nx;
  logic [NUM_W-1:0] num_y, num_x;
  item_t in_item;

  logic    tail_valid, pop, fb_valid, fb_take;
  item_t   tail;
  bundle_t fb;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_height <= SDIM_W'(1);
      src_width  <= SDIM_W'(1);
      dst_height <= DDIM_W'(1);
      dst_width  <= DDIM_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_SRC_HEIGHT: src_height <= pwdata[SDIM_W-1:0];
        REG_SRC_WIDTH:  src_width  <= pwdata[SDIM_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[DDIM_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[DDIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_HEIGHT: prdata = PDATA_W'(src_height);
      REG_SRC_WIDTH:  prdata = PDATA_W'(src_width);
      REG_DST_HEIGHT: prdata = PDATA_W'(dst_height);
      REG_DST_WIDTH:  prdata = PDATA_W'(dst_width);
      default:        prdata = '0;
    endcase
  end

  // Out-of-range sizes saturate; a zero destination size makes every read an error.
  always_comb begin
    sh = (src_height == '0) ? SDIM_W'(1) :
         (src_height > SDIM_W'(MAX_SRC_DIM)) ? SDIM_W'(MAX_SRC_DIM) : src_height;
    sw = (src_width == '0) ? SDIM_W'(1) :
         (src_width > SDIM_W'(MAX_SRC_DIM)) ? SDIM_W'(MAX_SRC_DIM) : src_width;
    dh = (dst_height > DDIM_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_height;
    dw = (dst_width > DDIM_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_width;
  end

  // Source position numerator (2*d+1)*S - D, clamped at zero.
  always_comb begin
    py = (NUM_W + 1)'({request.row, 1'b1}) * (NUM_W + 1)'(sh);
    px = (NUM_W + 1)'({request.col, 1'b1}) * (NUM_W + 1)'(sw);
    ny = py - (NUM_W + 1)'(dh);
    nx = px - (NUM_W + 1)'(dw);
    num_y = (py < (NUM_W + 1)'(dh)) ? '0 : ny[NUM_W-1:0];
    num_x = (px < (NUM_W + 1)'(dw)) ? '0 : nx[NUM_W-1:0];

    if (!request.operation) begin
      in_item.kind = ((request.row < COORD_W'(sh)) && (request.col < COORD_W'(sw))) ?
                     KIND_WRITE : KIND_SKIP;
    end else begin
      in_item.kind = ((DDIM_W'(request.row) >= dh) || (DDIM_W'(request.col) >= dw)) ?
                     KIND_ERROR : KIND_READ;
    end
    in_item.waddr = {request.row[SIDX_W-1:0], request.col[SIDX_W-1:0]};
    in_item.pix   = {request.blue_in, request.green_in, request.red_in};
    in_item.ylast = SIDX_W'(sh - 1'b1);
    in_item.xlast = SIDX_W'(sw - 1'b1);
    in_item.den_y = {dh, 1'b0};
    in_item.den_x = {dw, 1'b0};
    in_item.rem_y = num_y[NUM_W-1:SIDX_W];
    in_item.rem_x = num_x[NUM_W-1:SIDX_W];
    in_item.quo_y = {num_y[SIDX_W-1:0], WEIGHT_BITS'(0)};
    in_item.quo_x = {num_x[SIDX_W-1:0], WEIGHT_BITS'(0)};
  end

  brn_divpipe u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .in_item    (in_item),
    .tail_valid (tail_valid),
    .tail       (tail),
    .pop        (pop)
  );

  brn_fetch u_fetch (
    .clk        (clk),
    .rst        (rst),
    .tail_valid (tail_valid),
    .tail       (tail),
    .pop        (pop),
    .fb_valid   (fb_valid),
    .fb         (fb),
    .fb_take    (fb_take)
  );

  brn_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .fb_valid (fb_valid),
    .fb       (fb),
    .fb_take  (fb_take),
    .result   (result)
  );

endmodule
